[rtl/core/adsr_pkg.sv]
package adsr_pkg;

    // fixed point and timing
    localparam int LEVEL_BITS  = 23;
    localparam int SAMPLE_RATE = 48000;
    localparam int LEVEL_W     = LEVEL_BITS + 1;
    localparam int TIME_W      = 22;
    localparam int NOTE_W      = 7;
    localparam int KS_W        = 3;
    localparam int ACTION_W    = 2;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int KS_BASE     = 64;
    localparam int KS_SHIFT    = 6;
    localparam int MS_PER_S    = 1000;

    // 64 + key_scale * note, worst case 64 + 7 * 127
    localparam int NUM_W       = 10;

    // full * num / (64 * time) == (num << (LEVEL_BITS - 6)) / time
    localparam int DIVIDEND_W  = NUM_W + LEVEL_BITS - KS_SHIFT;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

    // width for the minimum-time compare
    localparam int CMP_W       = 48;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(64'd1 << LEVEL_BITS);
    localparam logic [LEVEL_W-1:0] CLAMP_STEP =
        LEVEL_W'(((64'd1 << LEVEL_BITS) * MS_PER_S) / SAMPLE_RATE);

    localparam logic [CMP_W-1:0] TIME_MUL = CMP_W'(KS_BASE * MS_PER_S);
    localparam logic [CMP_W-1:0] RATE_MUL = CMP_W'(SAMPLE_RATE);

    // register reset values
    localparam logic [TIME_W-1:0]  ATTACK_RST  = TIME_W'(480);
    localparam logic [TIME_W-1:0]  DECAY_RST   = TIME_W'(4800);
    localparam logic [TIME_W-1:0]  RELEASE_RST = TIME_W'(4800);
    localparam logic [TIME_W-1:0]  SUSTAIN_RST = TIME_W'(0);
    localparam logic [LEVEL_W-1:0] SLEVEL_RST  = LEVEL_W'(4194304);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_TIME   = 3'd0,
        CFG_DECAY_TIME    = 3'd1,
        CFG_RELEASE_TIME  = 3'd2,
        CFG_SUSTAIN_TIME  = 3'd3,
        CFG_SUSTAIN_LEVEL = 3'd4,
        CFG_KEY_SCALE     = 3'd5,
        CFG_HOLD          = 3'd6
    } cfg_index_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_KEY_ON  = 2'd1,
        ACT_KEY_OFF = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    // which step the key-on sequence is working on
    typedef enum logic [1:0] {
        SEL_ATTACK  = 2'd0,
        SEL_DECAY   = 2'd1,
        SEL_RELEASE = 2'd2,
        SEL_SUSTAIN = 2'd3
    } step_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PREP = 2'd1,
        ST_DIV  = 2'd2,
        ST_EMIT = 2'd3
    } seq_state_t;

endpackage

[rtl/core/adsr_div.sv]
module adsr_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [adsr_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [adsr_pkg::TIME_W-1:0]         divisor,
    output logic                                done,
    output logic [adsr_pkg::DIVIDEND_W-1:0]     quotient
);

    logic [adsr_pkg::TIME_W-1:0]     rem_reg, rem_next;
    logic [adsr_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [adsr_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [adsr_pkg::TIME_W:0]       shifted;
    logic [adsr_pkg::TIME_W:0]       diff;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[adsr_pkg::DIVIDEND_W-1]};
        diff      = shifted - {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = adsr_pkg::DIV_CNT_W'(adsr_pkg::DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = diff[adsr_pkg::TIME_W-1:0];
                quo_next = {quo_reg[adsr_pkg::DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[adsr_pkg::TIME_W-1:0];
                quo_next = {quo_reg[adsr_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - adsr_pkg::DIV_CNT_W'(1);
            if (cnt_reg == adsr_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/adsr_envelope_generator_unit.sv]
// channel   dir  width  contents
// s_axis    in   16     action, note
// m_axis    out  32     level, phase
// cfg       in   24     register write, index 0..6
//
// tick, key off and unused codes go from accept straight to the result state
// key on computes four steps in turn on one shared restoring divider, each
// set up in the prep state; s_axis takes no new item until the result state is left
// reset clears the envelope, all steps and the register file to defaults
// a waiting result holds the block in its result state until m_axis_tready
module adsr_envelope_generator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] action, [8:2] note
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [23:0] level, [26:24] phase
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    // configuration registers
    logic [adsr_pkg::TIME_W-1:0]  attack_time_reg, decay_time_reg;
    logic [adsr_pkg::TIME_W-1:0]  release_time_reg, sustain_time_reg;
    logic [adsr_pkg::LEVEL_W-1:0] sustain_level_reg;
    logic [adsr_pkg::KS_W-1:0]    key_scale_reg;
    logic                         hold_reg;

    adsr_pkg::seq_state_t         state_reg, state_next;
    adsr_pkg::phase_t             phase_reg, phase_next;
    logic [adsr_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [adsr_pkg::LEVEL_W-1:0] step_reg [4];
    logic [adsr_pkg::LEVEL_W-1:0] step_val;
    logic                         step_we;
    logic [1:0]                   sel_reg, sel_next;
    logic [adsr_pkg::NUM_W-1:0]   num_reg, num_next;
    logic                         out_valid_reg, out_valid_next;
    logic [adsr_pkg::LEVEL_W-1:0] out_level_reg;
    adsr_pkg::phase_t             out_phase_reg;
    logic                         out_load;

    adsr_pkg::action_t            in_action;
    logic [adsr_pkg::NOTE_W-1:0]  in_note;
    logic                         in_acc;

    logic [adsr_pkg::TIME_W-1:0]     time_sel;
    logic [adsr_pkg::CMP_W-1:0]      cmp_time, cmp_rate;
    logic                            below_min;
    logic                            div_start;
    logic                            div_done;
    logic [adsr_pkg::DIVIDEND_W-1:0] div_quo;
    logic [adsr_pkg::DIVIDEND_W-1:0] dividend;

    // tick datapath
    adsr_pkg::phase_t             tick_phase;
    logic [adsr_pkg::LEVEL_W-1:0] tick_level;
    logic [adsr_pkg::LEVEL_W-1:0] limit;
    logic [adsr_pkg::LEVEL_W:0]   rise_sum;
    logic [adsr_pkg::LEVEL_W-1:0] fall_step, fall_floor;
    adsr_pkg::phase_t             fall_phase;
    logic                         fall_en;
    logic [adsr_pkg::LEVEL_W:0]   fall_bound;

    assign in_action     = adsr_pkg::action_t'(s_axis_tdata[1:0]);
    assign in_note       = s_axis_tdata[8:2];
    assign s_axis_tready = (state_reg == adsr_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_time_reg   <= adsr_pkg::ATTACK_RST;
            decay_time_reg    <= adsr_pkg::DECAY_RST;
            release_time_reg  <= adsr_pkg::RELEASE_RST;
            sustain_time_reg  <= adsr_pkg::SUSTAIN_RST;
            sustain_level_reg <= adsr_pkg::SLEVEL_RST;
            key_scale_reg     <= '0;
            hold_reg          <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (adsr_pkg::cfg_index_t'(cfg_index))
                adsr_pkg::CFG_ATTACK_TIME:   attack_time_reg  <= cfg_data[adsr_pkg::TIME_W-1:0];
                adsr_pkg::CFG_DECAY_TIME:    decay_time_reg   <= cfg_data[adsr_pkg::TIME_W-1:0];
                adsr_pkg::CFG_RELEASE_TIME:  release_time_reg <= cfg_data[adsr_pkg::TIME_W-1:0];
                adsr_pkg::CFG_SUSTAIN_TIME:  sustain_time_reg <= cfg_data[adsr_pkg::TIME_W-1:0];
                adsr_pkg::CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data;
                adsr_pkg::CFG_KEY_SCALE:     key_scale_reg    <= cfg_data[adsr_pkg::KS_W-1:0];
                adsr_pkg::CFG_HOLD:          hold_reg         <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // one tick of the envelope
    always_comb
    begin
        limit      = (sustain_level_reg > adsr_pkg::FULL_SCALE) ?
                     adsr_pkg::FULL_SCALE : sustain_level_reg;
        rise_sum   = {1'b0, level_reg} + {1'b0, step_reg[adsr_pkg::SEL_ATTACK]};
        tick_level = level_reg;
        tick_phase = phase_reg;
        fall_en    = 1'b0;
        fall_step  = step_reg[adsr_pkg::SEL_RELEASE];
        fall_floor = '0;
        fall_phase = adsr_pkg::PH_IDLE;
        case (phase_reg)
            adsr_pkg::PH_ATTACK:
            begin
                if (rise_sum >= {1'b0, adsr_pkg::FULL_SCALE})
                begin
                    tick_level = adsr_pkg::FULL_SCALE;
                    tick_phase = adsr_pkg::PH_DECAY;
                end
                else
                begin
                    tick_level = rise_sum[adsr_pkg::LEVEL_W-1:0];
                end
            end
            adsr_pkg::PH_DECAY:
            begin
                if (level_reg > limit)
                begin
                    fall_en    = 1'b1;
                    fall_step  = step_reg[adsr_pkg::SEL_DECAY];
                    fall_floor = limit;
                    fall_phase = adsr_pkg::PH_SUSTAIN;
                end
                else
                begin
                    tick_level = limit;
                    tick_phase = adsr_pkg::PH_SUSTAIN;
                end
            end
            adsr_pkg::PH_SUSTAIN:
            begin
                if (!hold_reg)
                begin
                    fall_en = 1'b1;
                end
                else if (step_reg[adsr_pkg::SEL_SUSTAIN] != '0)
                begin
                    fall_en   = 1'b1;
                    fall_step = step_reg[adsr_pkg::SEL_SUSTAIN];
                end
            end
            adsr_pkg::PH_RELEASE:
            begin
                fall_en = 1'b1;
            end
            default: ;
        endcase
        fall_bound = {1'b0, fall_floor} + {1'b0, fall_step};
        if (fall_en)
        begin
            if ({1'b0, level_reg} <= fall_bound)
            begin
                tick_level = fall_floor;
                tick_phase = fall_phase;
            end
            else
            begin
                tick_level = level_reg - fall_step;
            end
        end
    end

    // step set-up for the time under work
    always_comb
    begin
        case (adsr_pkg::step_sel_t'(sel_reg))
            adsr_pkg::SEL_ATTACK:  time_sel = attack_time_reg;
            adsr_pkg::SEL_DECAY:   time_sel = decay_time_reg;
            adsr_pkg::SEL_RELEASE: time_sel = release_time_reg;
            default:               time_sel = sustain_time_reg;
        endcase
        cmp_time  = adsr_pkg::CMP_W'(time_sel) * adsr_pkg::TIME_MUL;
        cmp_rate  = adsr_pkg::CMP_W'(num_reg) * adsr_pkg::RATE_MUL;
        below_min = cmp_time < cmp_rate;
        dividend  = adsr_pkg::DIVIDEND_W'(num_reg)
                    << (adsr_pkg::LEVEL_BITS - adsr_pkg::KS_SHIFT);
    end

    adsr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (time_sel),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        level_next     = level_reg;
        sel_next       = sel_reg;
        num_next       = num_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        step_we        = 1'b0;
        step_val       = adsr_pkg::CLAMP_STEP;
        div_start      = 1'b0;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            adsr_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = adsr_pkg::ST_EMIT;
                    case (in_action)
                        adsr_pkg::ACT_TICK:
                        begin
                            phase_next = tick_phase;
                            level_next = tick_level;
                        end
                        adsr_pkg::ACT_KEY_ON:
                        begin
                            phase_next = adsr_pkg::PH_ATTACK;
                            level_next = '0;
                            sel_next   = adsr_pkg::SEL_ATTACK;
                            num_next   = adsr_pkg::NUM_W'(adsr_pkg::KS_BASE)
                                         + adsr_pkg::NUM_W'(key_scale_reg)
                                         * adsr_pkg::NUM_W'(in_note);
                            state_next = adsr_pkg::ST_PREP;
                        end
                        adsr_pkg::ACT_KEY_OFF:
                        begin
                            if (phase_reg != adsr_pkg::PH_IDLE)
                            begin
                                phase_next = adsr_pkg::PH_RELEASE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            adsr_pkg::ST_PREP:
            begin
                if (sel_reg == adsr_pkg::SEL_SUSTAIN && sustain_time_reg == '0)
                begin
                    step_we  = 1'b1;
                    step_val = '0;
                end
                else if (below_min)
                begin
                    step_we = 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = adsr_pkg::ST_DIV;
                end
                if (step_we)
                begin
                    sel_next = sel_reg + 2'd1;
                    if (sel_reg == adsr_pkg::SEL_SUSTAIN)
                    begin
                        state_next = adsr_pkg::ST_EMIT;
                    end
                end
            end
            adsr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    step_we  = 1'b1;
                    // never below one so the phase always moves on
                    step_val = (div_quo == '0) ? adsr_pkg::LEVEL_W'(1) :
                               div_quo[adsr_pkg::LEVEL_W-1:0];
                    sel_next = sel_reg + 2'd1;
                    state_next = (sel_reg == adsr_pkg::SEL_SUSTAIN) ?
                                 adsr_pkg::ST_EMIT : adsr_pkg::ST_PREP;
                end
            end
            adsr_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = adsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = adsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adsr_pkg::ST_IDLE;
            phase_reg     <= adsr_pkg::PH_IDLE;
            level_reg     <= '0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
            step_reg[0]   <= '0;
            step_reg[1]   <= '0;
            step_reg[2]   <= '0;
            step_reg[3]   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
            if (step_we)
            begin
                step_reg[sel_reg] <= step_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        if (out_load)
        begin
            out_level_reg <= level_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_phase_reg, out_level_reg};

endmodule
